// ===== rtl/core/rgbhe_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhe_pkg
// Shared types and constants of the RGB histogram equalizer.
// ----------------------------------------------------------------------------
package rgbhe_pkg;

    localparam int PIX_BITS  = 24;     // width of the pixel count register
    localparam int CH_BITS   = 8;      // width of one color channel
    localparam int NUM_LANES = 3;      // red, green, blue

    localparam logic MODE_COUNT = 1'b0;
    localparam logic MODE_REMAP = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [CH_BITS-1:0] red_in;
        logic [CH_BITS-1:0] green_in;
        logic [CH_BITS-1:0] blue_in;
        logic               last_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic [CH_BITS-1:0] red_out;
        logic [CH_BITS-1:0] green_out;
        logic [CH_BITS-1:0] blue_out;
        logic               end_of_image;
    } pixel_out_t;

    // Commands from the top-level sequencer to every channel lane
    typedef struct packed {
        logic count_rd;     // read the bin addressed by the pixel
        logic count_wr;     // write back the incremented bin
        logic clr;          // zero the addressed bin
        logic build_start;  // start the table build
        logic remap_rd;     // read the level table
    } lane_ctl_t;

endpackage

// ===== rtl/core/rgbhe_lane.sv =====
// ----------------------------------------------------------------------------
// rgbhe_lane
// One color channel: histogram memory, level table memory and the table
// build sequencer (cumulative scan, minimum search, per-bin level division).
// ----------------------------------------------------------------------------
module rgbhe_lane #(
    parameter int LEVELS     = 256,
    parameter int COUNT_BITS = 24,
    localparam int LBITS     = $clog2(LEVELS)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rgbhe_pkg::lane_ctl_t              ctl,
    input  logic [LBITS-1:0]                  addr,
    input  logic [rgbhe_pkg::PIX_BITS-1:0]    pixel_count,
    output logic                              busy,
    output logic [rgbhe_pkg::CH_BITS-1:0]     level
);

    localparam int ACC_BITS  = COUNT_BITS + LBITS;
    localparam int PROD_BITS = ACC_BITS + LBITS;
    localparam int DIV_A     = PROD_BITS + 2;
    localparam int DIV_B     = rgbhe_pkg::PIX_BITS + 10;
    localparam int DIV_BITS  = (DIV_A > DIV_B) ? DIV_A : DIV_B;
    localparam int CH        = rgbhe_pkg::CH_BITS;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_SRD  = 4'd1;
    localparam logic [3:0] B_SACC = 4'd2;
    localparam logic [3:0] B_MRD  = 4'd3;
    localparam logic [3:0] B_MACC = 4'd4;
    localparam logic [3:0] B_MUL  = 4'd5;
    localparam logic [3:0] B_SAT  = 4'd6;
    localparam logic [3:0] B_DIV  = 4'd7;
    localparam logic [3:0] B_WR   = 4'd8;

    logic [COUNT_BITS-1:0] cnt_mem [LEVELS];
    logic [CH-1:0]         lvl_mem [LEVELS];

    logic [3:0]            state_reg;
    logic [LBITS-1:0]      idx_reg;
    logic [LBITS-1:0]      bin_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic [CH-1:0]         level_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [ACC_BITS-1:0]   lo_reg;
    logic                  found_reg;
    logic [ACC_BITS-1:0]   num_reg;
    logic [rgbhe_pkg::PIX_BITS-1:0] den_reg;
    logic                  zero_reg;
    logic                  sat_reg;
    logic [DIV_BITS-1:0]   rem_reg;
    logic [DIV_BITS-1:0]   dv_reg;
    logic [2:0]            step_reg;
    logic [CH-1:0]         q_reg;

    logic [LBITS-1:0]      rd_addr;
    logic                  rd_en;
    logic [ACC_BITS-1:0]   acc_next;
    logic [DIV_BITS-1:0]   vdiv;
    logic [CH-1:0]         level_next;

    always_comb begin
        rd_en    = ctl.count_rd || (state_reg == B_SRD) || (state_reg == B_MRD);
        rd_addr  = (state_reg == B_SRD || state_reg == B_MRD) ? idx_reg : addr;
        acc_next = acc_reg + ACC_BITS'(cnt_rd_reg);
        vdiv     = DIV_BITS'(den_reg) << 1;
        if (zero_reg) begin
            level_next = '0;
        end else if (sat_reg) begin
            level_next = '1;
        end else begin
            level_next = q_reg;
        end
    end

    // Histogram memory: one read and one write port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            cnt_rd_reg <= cnt_mem[rd_addr];
        end
        if (ctl.clr) begin
            cnt_mem[addr] <= '0;
        end else if (ctl.count_wr) begin
            cnt_mem[bin_reg] <= (&cnt_rd_reg) ? cnt_rd_reg : cnt_rd_reg + 1'b1;
        end
        if (ctl.count_rd) begin
            bin_reg <= addr;
        end
    end

    // Level table memory
    always_ff @(posedge aclk) begin
        if (ctl.remap_rd) begin
            level_reg <= lvl_mem[addr];
        end
        if (state_reg == B_WR) begin
            lvl_mem[idx_reg] <= level_next;
        end
    end

    // Build sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            unique case (state_reg)
                B_IDLE: begin
                    if (ctl.build_start) begin
                        state_reg <= B_SRD;
                    end
                end
                B_SRD:  state_reg <= B_SACC;
                B_SACC: state_reg <= (idx_reg == LBITS'(LEVELS - 1)) ? B_MRD : B_SRD;
                B_MRD:  state_reg <= B_MACC;
                B_MACC: state_reg <= B_MUL;
                B_MUL:  state_reg <= B_SAT;
                B_SAT:  state_reg <= B_DIV;
                B_DIV: begin
                    if (step_reg == 3'd0) begin
                        state_reg <= B_WR;
                    end
                end
                B_WR:   state_reg <= (idx_reg == LBITS'(LEVELS - 1)) ? B_IDLE : B_MRD;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                idx_reg   <= '0;
                acc_reg   <= '0;
                lo_reg    <= '0;
                found_reg <= 1'b0;
            end
            B_SACC: begin
                acc_reg <= acc_next;
                if (!found_reg && acc_next != '0) begin
                    lo_reg    <= acc_next;
                    found_reg <= 1'b1;
                end
                if (idx_reg == LBITS'(LEVELS - 1)) begin
                    idx_reg <= '0;
                    acc_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            B_MACC: begin
                acc_reg  <= acc_next;
                num_reg  <= acc_next - lo_reg;
                den_reg  <= pixel_count - lo_reg[rgbhe_pkg::PIX_BITS-1:0];
                zero_reg <= (ACC_BITS'(pixel_count) <= lo_reg) || (acc_next < lo_reg);
            end
            B_MUL: begin
                rem_reg <= ((DIV_BITS'(num_reg) * DIV_BITS'(LEVELS - 1)) << 1)
                           + DIV_BITS'(den_reg);
            end
            B_SAT: begin
                sat_reg  <= rem_reg >= (vdiv << 8);
                dv_reg   <= vdiv << 7;
                step_reg <= 3'd7;
                q_reg    <= '0;
            end
            B_DIV: begin
                // one restoring step per cycle, quotient MSB first
                if (rem_reg >= dv_reg) begin
                    rem_reg <= rem_reg - dv_reg;
                    q_reg   <= {q_reg[CH-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[CH-2:0], 1'b0};
                end
                dv_reg   <= dv_reg >> 1;
                step_reg <= step_reg - 1'b1;
            end
            B_WR: begin
                idx_reg <= idx_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign busy  = (state_reg != B_IDLE);
    assign level = level_reg;

endmodule

// ===== rtl/core/rgb_histogram_equalizer.sv =====
// ----------------------------------------------------------------------------
// rgb_histogram_equalizer
// Per-channel histogram equalization of an RGB image streamed in two passes.
// ----------------------------------------------------------------------------
// Stream the image once with mode 0 (count) and once with mode 1 (remap).
// A count transaction reads and then writes back the histogram bin memory.
// After the count transaction marked last the block stalls its input while
// each channel lane builds its level table: a cumulative scan over the bins,
// then the level of each bin, set by the 8-step restoring divider of each
// lane. A remap transaction reads the level table, then loads the output
// register, and yields one result; count transactions yield none. After
// reset and after the remap transaction marked last, a clearing pass over
// all bins zeroes the histograms; no input is taken meanwhile. Until the
// first table build, remapped pixels pass through unchanged. pixel_count
// may be written at any time the block is idle.
module rgb_histogram_equalizer #(
    parameter int LEVELS     = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rgbhe_pkg::pixel_in_t           s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output rgbhe_pkg::pixel_out_t          m_data,
    input  logic                           cfg_wr_en,
    input  logic [rgbhe_pkg::PIX_BITS-1:0] cfg_wr_data
);

    localparam int LBITS = $clog2(LEVELS);
    localparam int CH    = rgbhe_pkg::CH_BITS;
    localparam int NL    = rgbhe_pkg::NUM_LANES;

    // Sequencer states
    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CWR   = 3'd2;
    localparam logic [2:0] ST_BUILD = 3'd3;
    localparam logic [2:0] ST_RMP   = 3'd4;

    logic [2:0]                     state_reg;
    logic [LBITS-1:0]               clr_idx_reg;
    logic [rgbhe_pkg::PIX_BITS-1:0] pixel_count_reg;
    logic                           table_ready_reg;
    rgbhe_pkg::pixel_in_t           pix_reg;
    logic                           m_valid_reg;
    rgbhe_pkg::pixel_out_t          m_data_reg;

    rgbhe_pkg::lane_ctl_t           ctl;
    logic                           s_fire;
    logic                           load_out;
    logic [CH-1:0]                  ch_val     [NL];
    logic [LBITS-1:0]               lane_addr  [NL];
    logic [CH-1:0]                  lane_level [NL];
    logic [NL-1:0]                  lane_busy;
    logic [LBITS+CH-1:0]            ext_val    [NL];

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign load_out = (state_reg == ST_RMP) && (!m_valid_reg || m_ready);

    // Map channel values to bin addresses, saturating at the top bin;
    // during the clearing pass all lanes sweep the same address.
    always_comb begin
        ch_val[0] = s_data.red_in;
        ch_val[1] = s_data.green_in;
        ch_val[2] = s_data.blue_in;
        for (int i = 0; i < NL; i++) begin
            ext_val[i] = {{LBITS{1'b0}}, ch_val[i]};
            if (state_reg == ST_CLR) begin
                lane_addr[i] = clr_idx_reg;
            end else if (ext_val[i] >= (LBITS + CH)'(LEVELS)) begin
                lane_addr[i] = LBITS'(LEVELS - 1);
            end else begin
                lane_addr[i] = ext_val[i][LBITS-1:0];
            end
        end
    end

    always_comb begin
        ctl.count_rd    = s_fire && (s_data.mode == rgbhe_pkg::MODE_COUNT);
        ctl.remap_rd    = s_fire && (s_data.mode == rgbhe_pkg::MODE_REMAP);
        ctl.count_wr    = (state_reg == ST_CWR);
        ctl.build_start = (state_reg == ST_CWR) && pix_reg.last_pixel;
        ctl.clr         = (state_reg == ST_CLR);
    end

    // One lane per color channel
    for (genvar g = 0; g < NL; g++) begin : g_lane
        rgbhe_lane #(
            .LEVELS     (LEVELS),
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .addr        (lane_addr[g]),
            .pixel_count (pixel_count_reg),
            .busy        (lane_busy[g]),
            .level       (lane_level[g])
        );
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg <= rgbhe_pkg::PIX_BITS'(1);
        end else if (cfg_wr_en) begin
            pixel_count_reg <= cfg_wr_data;
        end
    end

    // Hold the accepted transaction for the following cycles
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pix_reg <= s_data;
        end
    end

    // Main sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLR;
            clr_idx_reg     <= '0;
            table_ready_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_CLR: begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == LBITS'(LEVELS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        state_reg <= (s_data.mode == rgbhe_pkg::MODE_COUNT) ? ST_CWR : ST_RMP;
                    end
                end
                ST_CWR: begin
                    state_reg <= pix_reg.last_pixel ? ST_BUILD : ST_IDLE;
                end
                ST_BUILD: begin
                    // lanes run in lockstep; wait for all of them
                    if (lane_busy == '0) begin
                        table_ready_reg <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                ST_RMP: begin
                    if (load_out) begin
                        clr_idx_reg <= '0;
                        state_reg   <= pix_reg.last_pixel ? ST_CLR : ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output register: merge the lane levels, or pass through before a build
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (table_ready_reg) begin
                m_data_reg.red_out   <= lane_level[0];
                m_data_reg.green_out <= lane_level[1];
                m_data_reg.blue_out  <= lane_level[2];
            end else begin
                m_data_reg.red_out   <= pix_reg.red_in;
                m_data_reg.green_out <= pix_reg.green_in;
                m_data_reg.blue_out  <= pix_reg.blue_in;
            end
            m_data_reg.end_of_image <= pix_reg.last_pixel;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // No input is taken while any lane is building its table
    a_no_input_in_build: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_busy != '0) |-> !s_ready)
        else $error("input accepted during table build");

    // A new result only ever follows a remap transaction
    a_result_from_remap: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RMP))
        else $error("result without remap transaction");

    // Once built, the level tables stay valid until reset
    a_table_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(table_ready_reg))
        else $error("table ready flag dropped");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB histogram equalizer: count and remap passes
// over small images with random pixels, pixel_count sweeps, random idling on
// both sides and one long output stall; results checked against a predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LVL      = 256;
    localparam int CMAX     = (1 << 24) - 1;
    localparam int WD_LIMIT = 20000;  // outlasts a full table build
    localparam int SETTLE   = 5000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    rgbhe_pkg::pixel_in_t  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    rgbhe_pkg::pixel_out_t m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [rgbhe_pkg::PIX_BITS-1:0] cfg_wr_data = '0;

    always #2 aclk = ~aclk;

    rgb_histogram_equalizer uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // Predictor state: histograms, level tables, pixel count
    int unsigned hist_r[LVL], hist_g[LVL], hist_b[LVL];
    logic [7:0]  lut_r[LVL], lut_g[LVL], lut_b[LVL];
    bit          lut_valid;
    int unsigned npix;

    rgbhe_pkg::pixel_out_t expected_pixels[$];
    int          n_err, n_sent, n_seen, n_images;
    bit          idle_src, idle_sink, long_stall;
    int          quiet;

    // Fill one level table from one histogram (per-channel min search)
    task automatic build_lut(input int unsigned h[LVL], output logic [7:0] t[LVL]);
        longint unsigned acc, lo, den, num, q;
        bit seen;
        longint unsigned cum[LVL];
        acc = 0; lo = 0; seen = 0;
        for (int i = 0; i < LVL; i++) begin
            acc += h[i];
            cum[i] = acc;
            if (!seen && acc != 0) begin
                lo = acc;
                seen = 1;
            end
        end
        for (int i = 0; i < LVL; i++) begin
            if (npix <= lo || cum[i] < lo) begin
                t[i] = 8'd0;
            end else begin
                den = npix - lo;
                num = cum[i] - lo;
                q = (2 * num * 255 + den) / (2 * den);
                t[i] = (q > 255) ? 8'd255 : q[7:0];
            end
        end
    endtask

    // Advance the predictor by one accepted transaction
    task automatic predict_pixel(input rgbhe_pkg::pixel_in_t p);
        rgbhe_pkg::pixel_out_t o;
        if (p.mode == rgbhe_pkg::MODE_COUNT) begin
            if (hist_r[p.red_in] < CMAX) hist_r[p.red_in]++;
            if (hist_g[p.green_in] < CMAX) hist_g[p.green_in]++;
            if (hist_b[p.blue_in] < CMAX) hist_b[p.blue_in]++;
            if (p.last_pixel) begin
                build_lut(hist_r, lut_r);
                build_lut(hist_g, lut_g);
                build_lut(hist_b, lut_b);
                lut_valid = 1;
            end
        end else begin
            if (lut_valid) begin
                o.red_out = lut_r[p.red_in];
                o.green_out = lut_g[p.green_in];
                o.blue_out = lut_b[p.blue_in];
            end else begin
                o.red_out = p.red_in;
                o.green_out = p.green_in;
                o.blue_out = p.blue_in;
            end
            o.end_of_image = p.last_pixel;
            expected_pixels.push_back(o);
            if (p.last_pixel) begin
                foreach (hist_r[i]) begin
                    hist_r[i] = 0; hist_g[i] = 0; hist_b[i] = 0;
                end
            end
        end
    endtask

    // Result checker: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_seen++;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                n_err++;
            end else begin
                rgbhe_pkg::pixel_out_t e;
                e = expected_pixels.pop_front();
                if (m_data.red_out !== e.red_out)
                    $display("%0t: red exp %0d got %0d", $time, e.red_out, m_data.red_out);
                if (m_data.green_out !== e.green_out)
                    $display("%0t: green exp %0d got %0d", $time, e.green_out,
                             m_data.green_out);
                if (m_data.blue_out !== e.blue_out)
                    $display("%0t: blue exp %0d got %0d", $time, e.blue_out, m_data.blue_out);
                if (m_data.end_of_image !== e.end_of_image)
                    $display("%0t: eoi exp %0b got %0b", $time, e.end_of_image,
                             m_data.end_of_image);
                if (m_data !== e) n_err++;
            end
        end
    end

    // Watchdog: count cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WD_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Sink: random stall bursts, one long hold-off, none at the end
    initial begin : sink
        int k;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_stall) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                long_stall = 0;
            end else if (idle_sink && $urandom_range(0, 5) == 0) begin
                k = $urandom_range(1, 8);
                m_ready <= 1'b0;
                repeat (k - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Drive one transaction: hold valid and payload until accepted
    task automatic send_pixel(input rgbhe_pkg::pixel_in_t p);
        if (idle_src && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pixel(p);
        n_sent++;
        @(negedge aclk);
    endtask

    // Drop valid, wait for all results, let the block settle, then write pixel_count
    task automatic drain_and_write(input int n);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        repeat (LVL * 16 + 50) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n[rgbhe_pkg::PIX_BITS-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        npix = n;
        @(negedge aclk);
    endtask

    function automatic rgbhe_pkg::pixel_in_t mk(bit m, int r, int g, int b, bit l);
        rgbhe_pkg::pixel_in_t p;
        p.mode = m; p.red_in = r[7:0]; p.green_in = g[7:0]; p.blue_in = b[7:0];
        p.last_pixel = l;
        return p;
    endfunction

    // One image: count pass then remap pass with random content
    task automatic run_image(input int w);
        rgbhe_pkg::pixel_in_t img[$];
        rgbhe_pkg::pixel_in_t p;
        int mx;
        mx = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 255);
        for (int i = 0; i < w; i++) begin
            p = mk(rgbhe_pkg::MODE_COUNT, $urandom_range(0, mx), $urandom_range(0, mx),
                   $urandom_range(0, 255), i == w - 1);
            img.push_back(p);
            send_pixel(p);
        end
        for (int i = 0; i < w; i++) begin
            p = img[i];
            p.mode = rgbhe_pkg::MODE_REMAP;
            if ($urandom_range(0, 9) == 0) p.red_in = 8'($urandom_range(0, 255));
            send_pixel(p);
        end
        n_images++;
    endtask

    // Directed table: expected value typed in where obvious, else predicted
    typedef struct {
        rgbhe_pkg::pixel_in_t  pix;
        bit                    known;
        rgbhe_pkg::pixel_out_t want;
    } row_t;
    row_t dir_rows[$];

    initial begin : stim
        row_t r;
        int w;
        n_err = 0; n_sent = 0; n_seen = 0; n_images = 0; quiet = 0;
        idle_src = 1; idle_sink = 1; long_stall = 0;
        foreach (hist_r[i]) begin
            hist_r[i] = 0; hist_g[i] = 0; hist_b[i] = 0;
        end
        lut_valid = 0; npix = 1;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Passthrough before any table, extremes of every field
        r.known = 1;
        r.pix = mk(rgbhe_pkg::MODE_REMAP, 0, 0, 0, 0);       r.want = '{0, 0, 0, 0};
        dir_rows.push_back(r);
        r.pix = mk(rgbhe_pkg::MODE_REMAP, 255, 255, 255, 0); r.want = '{255, 255, 255, 0};
        dir_rows.push_back(r);
        r.pix = mk(rgbhe_pkg::MODE_REMAP, 8'hAA, 8'h55, 8'h0F, 1);
        r.want = '{8'hAA, 8'h55, 8'h0F, 1};
        dir_rows.push_back(r);
        // Single pixel image with N = 1: divisor zero, every level 0
        r.pix = mk(rgbhe_pkg::MODE_COUNT, 9, 200, 255, 1);   r.known = 0;
        dir_rows.push_back(r);
        r.known = 1;
        r.pix = mk(rgbhe_pkg::MODE_REMAP, 9, 200, 255, 0);   r.want = '{0, 0, 0, 0};
        dir_rows.push_back(r);
        r.pix = mk(rgbhe_pkg::MODE_REMAP, 0, 255, 3, 1);     r.want = '{0, 0, 0, 1};
        dir_rows.push_back(r);
        // Counts accumulate across count passes; with more pixels than N = 1 every level is 0
        r.known = 0;
        r.pix = mk(rgbhe_pkg::MODE_COUNT, 0, 255, 100, 0);   dir_rows.push_back(r);
        r.pix = mk(rgbhe_pkg::MODE_COUNT, 255, 0, 100, 1);   dir_rows.push_back(r);
        r.pix = mk(rgbhe_pkg::MODE_COUNT, 128, 1, 7, 1);     dir_rows.push_back(r);
        r.pix = mk(rgbhe_pkg::MODE_REMAP, 0, 255, 100, 0);   dir_rows.push_back(r);
        r.pix = mk(rgbhe_pkg::MODE_REMAP, 255, 0, 7, 0);     dir_rows.push_back(r);
        r.pix = mk(rgbhe_pkg::MODE_REMAP, 128, 1, 99, 1);    dir_rows.push_back(r);

        foreach (dir_rows[i]) begin
            send_pixel(dir_rows[i].pix);
            if (dir_rows[i].known && expected_pixels[$] !== dir_rows[i].want) begin
                $display("%0t: directed row %0d exp %h predicted %h", $time, i,
                         dir_rows[i].want, expected_pixels[$]);
                n_err++;
            end
        end

        // Directed image with N = 4, then a random image with the largest pixel count
        drain_and_write(4);
        for (int i = 0; i < 4; i++)
            send_pixel(mk(rgbhe_pkg::MODE_COUNT, i * 85, 255 - i * 85, 7, i == 3));
        for (int i = 0; i < 4; i++)
            send_pixel(mk(rgbhe_pkg::MODE_REMAP, i * 85, 255 - i * 85, 7, i == 3));
        drain_and_write(24'hFFFFFF);
        run_image(6);

        // Random part: small images, pixel_count near, at and off image size
        long_stall = 1;
        while (n_sent < 1000) begin
            w = $urandom_range(0, 15) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 12);
            case ($urandom_range(0, 4))
                0: drain_and_write(1);
                1: drain_and_write(w + $urandom_range(0, 3));
                2: drain_and_write($urandom_range(1, w));
                default: drain_and_write(w);
            endcase
            if (n_sent > 850) begin
                idle_src = 0;
                idle_sink = 0;
            end
            run_image(w);
        end

        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        $display("Ran %0d transactions over %0d images, checked %0d remapped pixels.",
                 n_sent, n_images, n_seen);
        if (n_err == 0 && expected_pixels.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
